[rtl/rwf_pkg.sv]
`default_nettype none

package rwf_pkg;

	// image geometry
	localparam int MAX_WIDTH = 2048;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int WIDTH_W   = 12;
	localparam int SCALE_W   = 8;
	localparam int SUM_W     = 12;
	localparam int LUMA_W    = 10;

	// configuration register indexes
	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_SCALE  = 2'd1;
	localparam logic [1:0] CFG_FILTER = 2'd2;

	// index of the last window tap and of the last divider step
	localparam logic [3:0] LAST_TAP  = 4'd8;
	localparam logic [3:0] LAST_STEP = 4'(SUM_W - 1);

	// pixel: channel 0 red, 1 green, 2 blue
	typedef logic [2:0][7:0] pix_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_ACC,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} state_t;

	function automatic logic [LUMA_W-1:0] luma(input pix_t p);
		luma = LUMA_W'(p[0]) + LUMA_W'(p[1]) + LUMA_W'(p[2]);
	endfunction

endpackage

`default_nettype wire

[rtl/rgb_window_filter_3x3.sv]
// 3x3 window filter over a square RGB image streamed in raster order.
// Input channel: in_valid / in_stall carry one pixel per beat (in_red,
// in_green, in_blue) with frame_start marking row 0, column 0 of a frame.
// Output channel: out_valid / out_stall carry one beat per interior pixel
// with its position, filtered color and frame_last on the final one.
// Border pixels produce no output beat.
// Configuration: cfg_wen writes cfg_wdata into register cfg_index
// (0 image_width, 1 kernel_scale, 2 filter_enable); write only when idle.
// Each pixel does a read-modify-write of the two-row line memory: the
// read is issued on acceptance, the write-back in the window shift step.
// A border pixel takes only the accept and window shift steps. An
// interior pixel goes through, in order, the accept step issuing the
// line memory read, the window shift, a walk over the window taps
// for sums and the min/max search, a prepare step, the bit-serial
// divider and a step handing the result to the output register; sharpen
// skips the divider. The output register holds one beat; a new pixel is
// accepted while it waits, and the next result waits in the last step
// until it is taken.
// Reset clears counters, window registers and configuration (width 512,
// scale 9, filtering off); the line memory is not cleared.
`default_nettype none

module rgb_window_filter_3x3 (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration
	input  wire logic                         cfg_wen,
	input  wire logic [1:0]                   cfg_index,
	input  wire logic [rwf_pkg::WIDTH_W-1:0]  cfg_wdata,
	// pixel input
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [7:0]                   in_red,
	input  wire logic [7:0]                   in_green,
	input  wire logic [7:0]                   in_blue,
	input  wire logic                         frame_start,
	// result output
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [rwf_pkg::COL_W-1:0]         out_row,
	output logic [rwf_pkg::COL_W-1:0]         out_col,
	output logic [7:0]                        out_red,
	output logic [7:0]                        out_green,
	output logic [7:0]                        out_blue,
	output logic                              frame_last
);

	// configuration registers
	logic [rwf_pkg::WIDTH_W-1:0] width_q;
	logic [rwf_pkg::SCALE_W-1:0] scale_q;
	logic                        filt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= rwf_pkg::WIDTH_W'(512);
			scale_q <= rwf_pkg::SCALE_W'(9);
			filt_q  <= 1'b0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				rwf_pkg::CFG_WIDTH:  width_q <= cfg_wdata;
				rwf_pkg::CFG_SCALE:  scale_q <= cfg_wdata[rwf_pkg::SCALE_W-1:0];
				rwf_pkg::CFG_FILTER: filt_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// derived settings
	logic [rwf_pkg::WIDTH_W-1:0] eff_width;
	logic [rwf_pkg::SCALE_W-1:0] divisor;
	logic                        sharp_mode;

	always_comb begin
		if (width_q < rwf_pkg::WIDTH_W'(3))
			eff_width = rwf_pkg::WIDTH_W'(3);
		else if (width_q > rwf_pkg::WIDTH_W'(rwf_pkg::MAX_WIDTH))
			eff_width = rwf_pkg::WIDTH_W'(rwf_pkg::MAX_WIDTH);
		else
			eff_width = width_q;
		divisor    = (scale_q == '0) ? rwf_pkg::SCALE_W'(1) : scale_q;
		sharp_mode = !filt_q && (scale_q == rwf_pkg::SCALE_W'(1));
	end

	rwf_pkg::state_t state_q, state_d;

	logic                      accept;
	logic                      emit;
	logic                      slot_free;
	logic [3:0]                cnt_q;
	logic [rwf_pkg::COL_W-1:0] row_q, col_q;
	logic [rwf_pkg::COL_W-1:0] rd_addr;

	assign accept    = in_valid && (state_q == rwf_pkg::ST_IDLE);
	assign in_stall  = (state_q != rwf_pkg::ST_IDLE);
	assign slot_free = !out_valid || !out_stall;
	assign rd_addr   = frame_start ? '0 : col_q;

	// position of the pixel being processed is interior
	always_comb begin
		emit = (row_q >= rwf_pkg::COL_W'(2)) && (col_q >= rwf_pkg::COL_W'(2))
			&& ({1'b0, row_q} < eff_width) && ({1'b0, col_q} < eff_width);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rwf_pkg::ST_IDLE: if (in_valid) state_d = rwf_pkg::ST_LOOK;
			rwf_pkg::ST_LOOK: state_d = emit ? rwf_pkg::ST_ACC : rwf_pkg::ST_IDLE;
			rwf_pkg::ST_ACC:  if (cnt_q == rwf_pkg::LAST_TAP) state_d = rwf_pkg::ST_PREP;
			rwf_pkg::ST_PREP: state_d = sharp_mode ? rwf_pkg::ST_DONE : rwf_pkg::ST_DIV;
			rwf_pkg::ST_DIV:  if (cnt_q == rwf_pkg::LAST_STEP) state_d = rwf_pkg::ST_DONE;
			rwf_pkg::ST_DONE: if (slot_free) state_d = rwf_pkg::ST_IDLE;
			default:          state_d = rwf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= rwf_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// line memory: bits 23..0 two rows up, bits 47..24 one row up
	logic [47:0]       row_mem [rwf_pkg::MAX_WIDTH];
	logic [47:0]       rd_q;
	rwf_pkg::pix_t     pix_q;
	rwf_pkg::pix_t     top, mid;

	assign top = rd_q[23:0];
	assign mid = rd_q[47:24];

	always_ff @(posedge clk) begin
		if (accept)
			rd_q <= row_mem[rd_addr];
		if (state_q == rwf_pkg::ST_LOOK)
			row_mem[col_q] <= {pix_q, mid};
	end

	// pixel capture
	always_ff @(posedge clk) begin
		if (accept)
			pix_q <= {in_blue, in_green, in_red};
	end

	// position counters and window columns
	rwf_pkg::pix_t win_q [6];
	logic [rwf_pkg::WIDTH_W-1:0] col_inc, row_inc;

	assign col_inc = {1'b0, col_q} + rwf_pkg::WIDTH_W'(1);
	assign row_inc = {1'b0, row_q} + rwf_pkg::WIDTH_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			for (int i = 0; i < 6; i++)
				win_q[i] <= '0;
		end else if (accept && frame_start) begin
			row_q <= '0;
			col_q <= '0;
		end else if (state_q == rwf_pkg::ST_LOOK) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= pix_q;
			if (col_inc >= eff_width) begin
				col_q <= '0;
				row_q <= (row_inc >= eff_width) ? '0 : row_inc[rwf_pkg::COL_W-1:0];
			end else begin
				col_q <= col_inc[rwf_pkg::COL_W-1:0];
			end
		end
	end

	// window taps in raster order, walked one per cycle
	rwf_pkg::pix_t             tap_q [9];
	rwf_pkg::pix_t             ctr_q;
	rwf_pkg::pix_t             lo_q, hi_q;
	logic [rwf_pkg::LUMA_W-1:0] lov_q, hiv_q, cur_luma;
	logic [rwf_pkg::SUM_W-1:0]  tot_q [3];
	logic [rwf_pkg::COL_W-1:0]  res_row_q, res_col_q;
	logic                       res_last_q;

	assign cur_luma = rwf_pkg::luma(tap_q[0]);

	// sharpen value and divider numerator
	logic [rwf_pkg::SUM_W-1:0] num   [3];
	logic [7:0]                sharp [3];
	logic [rwf_pkg::SUM_W-1:0] c10;
	logic signed [rwf_pkg::SUM_W:0] sv;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			num[k] = filt_q ? tot_q[k] - rwf_pkg::SUM_W'(lo_q[k]) - rwf_pkg::SUM_W'(hi_q[k])
				: tot_q[k];
		end
		c10 = '0;
		sv  = '0;
		for (int k = 0; k < 3; k++) begin
			c10 = (rwf_pkg::SUM_W'(ctr_q[k]) << 3) + (rwf_pkg::SUM_W'(ctr_q[k]) << 1);
			sv  = signed'({1'b0, c10}) - signed'({1'b0, tot_q[k]});
			if (sv < 0)
				sharp[k] = 8'd0;
			else if (sv > (rwf_pkg::SUM_W+1)'(255))
				sharp[k] = 8'd255;
			else
				sharp[k] = sv[7:0];
		end
	end

	// restoring divider, one quotient bit per cycle for each channel
	logic [rwf_pkg::SUM_W-1:0]   quo_q [3];
	logic [rwf_pkg::SCALE_W:0]   rem_q [3];
	logic [rwf_pkg::SCALE_W:0]   trial [3];
	logic                        ge    [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			trial[k] = {rem_q[k][rwf_pkg::SCALE_W-1:0], quo_q[k][rwf_pkg::SUM_W-1]};
			ge[k]    = trial[k] >= {1'b0, divisor};
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (state_q == rwf_pkg::ST_LOOK || state_q == rwf_pkg::ST_PREP)
			cnt_q <= '0;
		else if (state_q == rwf_pkg::ST_ACC || state_q == rwf_pkg::ST_DIV)
			cnt_q <= cnt_q + 4'd1;
	end

	// window datapath
	always_ff @(posedge clk) begin
		case (state_q)
			rwf_pkg::ST_LOOK: begin
				tap_q[0]   <= win_q[0];
				tap_q[1]   <= win_q[3];
				tap_q[2]   <= top;
				tap_q[3]   <= win_q[1];
				tap_q[4]   <= win_q[4];
				tap_q[5]   <= mid;
				tap_q[6]   <= win_q[2];
				tap_q[7]   <= win_q[5];
				tap_q[8]   <= pix_q;
				ctr_q      <= win_q[4];
				res_row_q  <= row_q - rwf_pkg::COL_W'(1);
				res_col_q  <= col_q - rwf_pkg::COL_W'(1);
				res_last_q <= ({1'b0, row_q} == eff_width - rwf_pkg::WIDTH_W'(1))
					&& ({1'b0, col_q} == eff_width - rwf_pkg::WIDTH_W'(1));
			end
			rwf_pkg::ST_ACC: begin
				for (int i = 0; i < 8; i++)
					tap_q[i] <= tap_q[i+1];
				if (cnt_q == '0) begin
					for (int k = 0; k < 3; k++)
						tot_q[k] <= rwf_pkg::SUM_W'(tap_q[0][k]);
					lo_q  <= tap_q[0];
					hi_q  <= tap_q[0];
					lov_q <= cur_luma;
					hiv_q <= cur_luma;
				end else begin
					for (int k = 0; k < 3; k++)
						tot_q[k] <= tot_q[k] + rwf_pkg::SUM_W'(tap_q[0][k]);
					// least sum, later tap wins a tie
					if (cur_luma <= lov_q) begin
						lo_q  <= tap_q[0];
						lov_q <= cur_luma;
					end
					// greatest sum, earlier tap wins a tie
					if (cur_luma > hiv_q) begin
						hi_q  <= tap_q[0];
						hiv_q <= cur_luma;
					end
				end
			end
			rwf_pkg::ST_PREP: begin
				for (int k = 0; k < 3; k++) begin
					rem_q[k] <= '0;
					quo_q[k] <= sharp_mode ? rwf_pkg::SUM_W'(sharp[k]) : num[k];
				end
			end
			rwf_pkg::ST_DIV: begin
				for (int k = 0; k < 3; k++) begin
					rem_q[k] <= ge[k] ? trial[k] - {1'b0, divisor} : trial[k];
					quo_q[k] <= {quo_q[k][rwf_pkg::SUM_W-2:0], ge[k]};
				end
			end
			default: ;
		endcase
	end

	// output register
	logic load_out;

	assign load_out = (state_q == rwf_pkg::ST_DONE) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (load_out)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_row    <= res_row_q;
			out_col    <= res_col_q;
			out_red    <= quo_q[0][7:0];
			out_green  <= quo_q[1][7:0];
			out_blue   <= quo_q[2][7:0];
			frame_last <= res_last_q;
		end
	end

endmodule

`default_nettype wire

[tb/tb_rgb_window_filter_3x3.sv]
`timescale 1ns / 100ps

module tb_rgb_window_filter_3x3;
	import rwf_pkg::*;

	// index with no register behind it; writes there change nothing
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [COL_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic             last;
	} filtered_t;

	// one line memory word: pixel one row up and pixel two rows up
	typedef struct packed {
		pix_t one_up;
		pix_t two_up;
	} line_entry_t;

	// predicts filtered pixels from the accepted stream and checks them in order
	class filter_scoreboard;
		line_entry_t line_mem [MAX_WIDTH];
		pix_t        win [6];
		int unsigned row_pos;
		int unsigned col_pos;
		logic [WIDTH_W-1:0] width_reg;
		logic [SCALE_W-1:0] scale_reg;
		bit          filt_reg;
		filtered_t   filtered_q [$];
		int unsigned mismatches;

		function new();
			foreach (win[i]) win[i] = '0;
			row_pos = 0;
			col_pos = 0;
			width_reg = 12'd512;
			scale_reg = 8'd9;
			filt_reg = 1'b0;
			mismatches = 0;
		endfunction

		task report(input string msg);
			if (mismatches < 200) $display("ERROR @%0t: %s", $realtime, msg);
			mismatches++;
		endtask

		function int unsigned outstanding();
			return filtered_q.size();
		endfunction

		function void write_reg(input logic [1:0] idx, input logic [WIDTH_W-1:0] data);
			case (idx)
				CFG_WIDTH:  width_reg = data;
				CFG_SCALE:  scale_reg = data[SCALE_W-1:0];
				CFG_FILTER: filt_reg = data[0];
				default: ;
			endcase
		endfunction

		function int unsigned eff_width();
			int unsigned w;
			w = width_reg;
			if (w < 3) w = 3;
			if (w > MAX_WIDTH) w = MAX_WIDTH;
			return w;
		endfunction

		// every line memory entry across the current width holds known pixels
		function bit line_ready();
			for (int c = 0; c < int'(eff_width()); c++)
				if ($isunknown(line_mem[c])) return 1'b0;
			return 1'b1;
		endfunction

		function int unsigned luma_of(input pix_t p);
			return 32'(p[0]) + 32'(p[1]) + 32'(p[2]);
		endfunction

		// one channel of the window through the selected kernel
		function logic [7:0] apply_kernel(input pix_t taps [9], input int k,
				input int lo, input int hi);
			int total;
			int divisor;
			int v;
			total = 0;
			for (int i = 0; i < 9; i++) total += int'(taps[i][k]);
			divisor = (scale_reg == 0) ? 1 : int'(scale_reg);
			if (filt_reg) begin
				total -= int'(taps[lo][k]) + int'(taps[hi][k]);
				return 8'(total / divisor);
			end
			if (scale_reg != 8'd1) return 8'(total / divisor);
			v = 10 * int'(taps[4][k]) - total;
			if (v < 0) v = 0;
			if (v > 255) v = 255;
			return 8'(v);
		endfunction

		function void take_pixel(input pix_t p, input bit fs);
			line_entry_t entry;
			pix_t        top;
			pix_t        mid;
			pix_t        taps [9];
			int unsigned eff;
			int unsigned s;
			int unsigned lo_luma;
			int          hi_luma;
			int          lo;
			int          hi;
			filtered_t   beat;
			if (fs) begin
				row_pos = 0;
				col_pos = 0;
			end
			eff = eff_width();
			entry = line_mem[col_pos % MAX_WIDTH];
			top = entry.two_up;
			mid = entry.one_up;
			line_mem[col_pos % MAX_WIDTH] = '{one_up: p, two_up: mid};

			taps[0] = win[0]; taps[1] = win[3]; taps[2] = top;
			taps[3] = win[1]; taps[4] = win[4]; taps[5] = mid;
			taps[6] = win[2]; taps[7] = win[5]; taps[8] = p;

			// interior pixel: window complete around (row-1, col-1)
			if (row_pos >= 2 && col_pos >= 2 && row_pos < eff && col_pos < eff) begin
				lo = 0;
				hi = 0;
				lo_luma = 766;
				hi_luma = -1;
				for (int i = 0; i < 9; i++) begin
					s = luma_of(taps[i]);
					if (s <= lo_luma) begin
						lo_luma = s;
						lo = i;
					end
					if (int'(s) > hi_luma) begin
						hi_luma = int'(s);
						hi = i;
					end
				end
				beat.row = COL_W'(row_pos - 1);
				beat.col = COL_W'(col_pos - 1);
				beat.red = apply_kernel(taps, 0, lo, hi);
				beat.green = apply_kernel(taps, 1, lo, hi);
				beat.blue = apply_kernel(taps, 2, lo, hi);
				beat.last = (row_pos == eff - 1 && col_pos == eff - 1);
				filtered_q.push_back(beat);
			end

			// shift the window one column
			win[0] = win[3];
			win[1] = win[4];
			win[2] = win[5];
			win[3] = top;
			win[4] = mid;
			win[5] = p;

			// raster position, wrapping at the effective width
			if (col_pos + 1 >= eff) begin
				col_pos = 0;
				if (row_pos + 1 >= eff) row_pos = 0;
				else row_pos++;
			end else begin
				col_pos++;
			end
		endfunction

		task check_filtered(input filtered_t got);
			filtered_t exp;
			if (filtered_q.size() == 0) begin
				report($sformatf("unexpected beat row %0d col %0d", got.row, got.col));
			end else begin
				exp = filtered_q.pop_front();
				if (got !== exp)
					report($sformatf({"beat mismatch: got row %0d col %0d rgb %h %h %h last %b,",
						" expected row %0d col %0d rgb %h %h %h last %b"},
						got.row, got.col, got.red, got.green, got.blue, got.last,
						exp.row, exp.col, exp.red, exp.green, exp.blue, exp.last));
			end
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_wen;
	logic [1:0]         cfg_index;
	logic [WIDTH_W-1:0] cfg_wdata;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         in_red;
	logic [7:0]         in_green;
	logic [7:0]         in_blue;
	logic               frame_start;
	logic               out_valid;
	logic               out_stall;
	logic [COL_W-1:0]   out_row;
	logic [COL_W-1:0]   out_col;
	logic [7:0]         out_red;
	logic [7:0]         out_green;
	logic [7:0]         out_blue;
	logic               frame_last;

	filter_scoreboard sb;
	int src_pct;
	int sink_pct;
	int hold_left;

	rgb_window_filter_3x3 dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_red      (in_red),
		.in_green    (in_green),
		.in_blue     (in_blue),
		.frame_start (frame_start),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_row     (out_row),
		.out_col     (out_col),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.frame_last  (frame_last)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("FAIL rgb_window_filter_3x3");
		$finish;
	end

	// result side: check accepted beats, random stall plus long hold-off
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				sb.check_filtered('{row: out_row, col: out_col, red: out_red,
					green: out_green, blue: out_blue, last: frame_last});
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < sink_pct);
			end
		end
	end

	function automatic pix_t make_pix(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		pix_t p;
		p[0] = r;
		p[1] = g;
		p[2] = b;
		return p;
	endfunction

	// style 0 random, 1 near the channel limits, 2 only 0/255 so sums tie often
	function automatic pix_t rand_pixel(input int style);
		pix_t p;
		int   pick;
		p = 24'($urandom);
		for (int k = 0; k < 3; k++) begin
			pick = $urandom_range(3);
			if (style == 1) p[k] = (pick < 2) ? 8'(pick) : 8'(252 + pick);
			else if (style == 2) p[k] = pick[0] ? 8'd255 : 8'd0;
		end
		return p;
	endfunction

	function automatic logic [WIDTH_W-1:0] pick_width();
		int r;
		r = $urandom_range(99);
		if (r < 5) return WIDTH_W'($urandom_range(2));
		if (r < 7) return WIDTH_W'($urandom_range(2049, 4095));
		if (r < 15) return WIDTH_W'($urandom_range(10, 30));
		return WIDTH_W'($urandom_range(3, 9));
	endfunction

	function automatic logic [7:0] pick_scale();
		int r;
		r = $urandom_range(99);
		if (r < 25) return 8'd1;
		if (r < 32) return 8'd0;
		if (r < 40) return 8'd255;
		if (r < 55) return 8'd9;
		return 8'($urandom_range(2, 254));
	endfunction

	// one pixel beat, with random idle cycles in front
	task automatic send_pixel(input pix_t p, input bit fs);
		@(negedge clk);
		while (src_pct > 0 && $urandom_range(99) < src_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_red <= p[0];
		in_green <= p[1];
		in_blue <= p[2];
		frame_start <= fs;
		do @(posedge clk); while (in_stall);
		sb.take_pixel(p, fs);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [WIDTH_W-1:0] data);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// all registers, unused upper bits random
	task automatic program_filter(input logic [WIDTH_W-1:0] w, input logic [7:0] s,
			input bit f);
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_SCALE, {4'($urandom), s});
		write_reg(CFG_FILTER, {11'($urandom), f});
		if ($urandom_range(3) == 0) write_reg(CFG_UNUSED, WIDTH_W'($urandom));
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	// stop offering, let every expected beat arrive, then cover border pixel work
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.outstanding() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic run_directed();
		// sharpen: red clamps high, green clamps low, blue in range
		program_filter(12'd3, 8'd1, 1'b0);
		for (int i = 0; i < 9; i++)
			send_pixel((i == 4) ? make_pix(8'd255, 8'd0, 8'd30) :
				make_pix(8'd0, 8'd255, 8'd20), i == 0);
		// scale zero is a box blur by one; frame wraps without frame_start
		wait_idle();
		program_filter(12'd3, 8'd0, 1'b0);
		for (int i = 0; i < 9; i++)
			send_pixel(make_pix(8'd255, 8'd255, 8'd255), 1'b0);
		// width below range, extremum filter with every pixel sum tied
		wait_idle();
		program_filter(12'd0, 8'd255, 1'b1);
		for (int i = 0; i < 9; i++)
			send_pixel((i % 3 == 0) ? make_pix(8'd255, 8'd0, 8'd0) :
				(i % 3 == 1) ? make_pix(8'd0, 8'd255, 8'd0) :
				make_pix(8'd0, 8'd0, 8'd255), i == 0);
	endtask

	// width above range clamps to the full line, so the first row runs on unwrapped
	task automatic run_full_width();
		wait_idle();
		program_filter(12'hFFF, 8'd5, 1'b1);
		for (int i = 0; i < MAX_WIDTH / 16; i++)
			send_pixel(rand_pixel(0), i == 0);
	endtask

	task automatic run_random();
		int sent;
		int n;
		int style;
		bit fs_first;
		bit held;
		held = 1'b0;
		for (int ph = 0; ph < 4; ph++) begin
			sent = 0;
			while (sent < 320) begin
				wait_idle();
				case (ph)
					0: begin src_pct = 0; sink_pct = 0; end
					1: begin src_pct = 78; sink_pct = 0; end
					2: begin src_pct = 0; sink_pct = 78; end
					default: begin src_pct = 26; sink_pct = 26; end
				endcase
				program_filter(pick_width(), pick_scale(), $urandom_range(1));
				n = $urandom_range(40, 160);
				style = $urandom_range(2);
				// continuing a frame needs filled line entries across the width
				fs_first = ($urandom_range(9) < 8) || !sb.line_ready();
				for (int i = 0; i < n; i++) begin
					send_pixel(rand_pixel(style),
						(i == 0 && fs_first) || ($urandom_range(99) == 0));
					// long output hold-off while pixels keep coming
					if (ph == 0 && !held && sb.outstanding() > 0 && n - i > 30) begin
						hold_left = HOLD_CYCLES;
						held = 1'b1;
					end
				end
				sent += n;
			end
		end
	endtask

	// stimulus
	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		in_red = '0;
		in_green = '0;
		in_blue = '0;
		frame_start = 1'b0;
		src_pct = 0;
		sink_pct = 0;
		hold_left = 0;
		sb = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_directed();
		run_full_width();
		run_random();
		wait_idle();

		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("PASS rgb_window_filter_3x3");
		end else begin
			$display("FAIL rgb_window_filter_3x3");
		end
		$finish;
	end

endmodule
